>>> rtl/ahmn_pkg.sv
// ----------------------------------------------------------------------------
// ahmn_pkg
// Shared types, media strings and character codes of the media negotiator.
// ----------------------------------------------------------------------------
`default_nettype none

package ahmn_pkg;

  typedef enum logic [1:0] {
    MEDIA_JSON = 2'd0,
    MEDIA_LD   = 2'd1,
    MEDIA_GEO  = 2'd2
  } ahmn_media_t;

  localparam int unsigned NUM_MEDIA = 3;
  localparam int unsigned NUM_STR   = 5;

  // end-of-entry report from the parser to the selector
  typedef struct packed {
    logic               done;   // entry closed by comma or terminator
    logic               last;   // terminator byte, decision requested
    logic               hit;    // entry name matched a known media string
    ahmn_media_t        media;
    logic signed [10:0] q;      // quality in thousandths
  } ahmn_entry_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // fixed media strings, right aligned, most specific first
  localparam logic [159:0] MEDIA_STR [NUM_STR] = '{
    160'("application/geo+json"),
    160'("application/ld+json"),
    160'("application/json"),
    160'("application/*"),
    160'("*/*")
  };
  localparam logic [4:0] MEDIA_LEN [NUM_STR] = '{5'd20, 5'd19, 5'd16, 5'd13, 5'd3};

  // per string: does lower-case char lc sit at position pos
  function automatic logic [NUM_STR-1:0] media_match(input logic [7:0] lc,
                                                     input logic [4:0] pos);
    logic [NUM_STR-1:0] m;
    int                 base;
    m = '0;
    for (int i = 0; i < NUM_STR; i++) begin
      base = (int'(MEDIA_LEN[i]) - 1 - int'(pos)) * 8;
      if (pos < MEDIA_LEN[i]) begin
        m[i] = (lc == MEDIA_STR[i][base +: 8]);
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ahmn_byte_if.sv
// ----------------------------------------------------------------------------
// ahmn_byte_if
// Valid/ready channel carrying one header byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ahmn_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;

  modport source (output valid, output header_byte, input ready);
  modport sink   (input valid, input header_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/ahmn_type_if.sv
// ----------------------------------------------------------------------------
// ahmn_type_if
// Valid/ready channel carrying the negotiated media type.
// ----------------------------------------------------------------------------
`default_nettype none

interface ahmn_type_if;
  logic       valid;
  logic       ready;
  logic [1:0] chosen_type;

  modport source (output valid, output chosen_type, input ready);
  modport sink   (input valid, input chosen_type, output ready);
endinterface

`default_nettype wire

>>> rtl/accept_header_media_negotiator_unit.sv
// ----------------------------------------------------------------------------
// accept_header_media_negotiator_unit
// Byte-serial Accept header parser that picks a JSON representation.
// ----------------------------------------------------------------------------
// The header streams in one byte per transfer on in_ch; a zero byte ends the
// header and produces exactly one transfer on out_ch carrying the chosen type
// (0 plain json, 1 linked-data json, 2 geo json). Any other byte produces no
// result. The unit takes one byte every cycle unless a terminator stalls, as
// below: each byte is held in the input register and parsed by combinational
// logic and, if it is the terminator, moves on into the output register, so
// a result passes the input register and then the output register before it
// is offered on out_ch. Only a terminator stalls, and only while a previous
// result is still unclaimed in the output register; bytes queued behind it
// wait with it, and other bytes never stall on their own. After each decision
// all parse state returns to its reset values, ready for the next header.
// There is no configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module accept_header_media_negotiator_unit #(
  parameter int unsigned Q_TOKEN_MAX = 15,   // longest q value token, 4..15
  parameter int unsigned ORDER_BITS  = 16    // entry order counter width, 4..32
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ahmn_byte_if.sink   in_ch,
  ahmn_type_if.source out_ch
);
  import ahmn_pkg::*;

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  // output register
  logic        out_valid_r;
  ahmn_media_t out_type_r;

  logic          out_free;
  logic          s1_is_term;
  logic          s1_adv;
  ahmn_entry_t   entry;
  ahmn_media_t   chosen;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign s1_is_term = (s1_byte_r == CH_NUL);
  // a terminator needs room in the output register, other bytes never stall
  assign s1_adv     = s1_valid_r && (!s1_is_term || out_free);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.chosen_type = out_type_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // byte payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.header_byte;
    end
  end

  ahmn_parser #(
    .Q_TOKEN_MAX (Q_TOKEN_MAX)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .byte_in (s1_byte_r),
    .entry   (entry)
  );

  ahmn_select #(
    .ORDER_BITS (ORDER_BITS)
  ) u_select (
    .clk    (clk),
    .rst_n  (rst_n),
    .entry  (entry),
    .chosen (chosen)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (entry.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (entry.last) begin
      out_type_r <= chosen;
    end
  end

  // a terminator leaving the input register always yields a result
  a_term_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_is_term |=> out_valid_r)
    else $error("terminator did not produce a result");

  // a held byte is never dropped or altered
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_byte_r))
    else $error("input register lost a stalled byte");

  // the type code 3 is never produced
  a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_type_r != 2'd3)
    else $error("invalid chosen type");

  // a terminator only leaves when the output register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    entry.last |-> !out_valid_r || out_ch.ready)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> rtl/ahmn_parser.sv
// ----------------------------------------------------------------------------
// ahmn_parser
// Per-entry byte parser: name matching and q parameter decoding.
// ----------------------------------------------------------------------------
`default_nettype none

module ahmn_parser #(
  parameter int unsigned Q_TOKEN_MAX = 15
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic [7:0]          byte_in,
  output      ahmn_pkg::ahmn_entry_t entry
);
  import ahmn_pkg::*;

  localparam int unsigned TOK_W = $clog2(Q_TOKEN_MAX + 1);
  localparam logic [10:0] Q_SAT = 11'd1001;
  localparam logic [10:0] Q_ONE = 11'd1000;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LOW_Q = 8'h71;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;

  typedef enum logic [2:0] {
    PH_LEAD, PH_NAME, PH_PSEP, PH_PSKIP, PH_PQ, PH_PEQ, PH_QVAL, PH_QDONE
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [4:0]         len_r, len_nxt;
  logic [NUM_STR-1:0] match_r, match_nxt;
  logic               qfound_r, qfound_nxt;
  logic [10:0]        acc_r, acc_nxt;
  logic [1:0]         frac_r, frac_nxt;
  logic [TOK_W-1:0]   tok_r, tok_nxt;
  logic               started_r, started_nxt;
  logic               neg_r, neg_nxt;
  logic               dot_r, dot_nxt;

  logic [7:0]  lc;
  logic        is_blank, is_sep, is_digit, is_end;
  logic        do_name, do_value;
  logic [3:0]  digit;
  logic [14:0] acc_sum;
  logic [6:0]  weight;
  logic [2:0]  hit_idx;
  logic        hit;

  assign lc       = (byte_in >= CH_UP_A && byte_in <= CH_UP_Z) ? byte_in + 8'd32 : byte_in;
  assign is_blank = (byte_in == CH_SPACE) || (byte_in == CH_TAB);
  assign is_sep   = is_blank || (byte_in == CH_SEMI);
  assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  assign digit    = 4'(byte_in - CH_ZERO);
  assign is_end   = (byte_in == CH_NUL) || (byte_in == CH_COMMA);
  assign do_name  = (phase_r == PH_LEAD && !is_blank) || (phase_r == PH_NAME);
  assign do_value = (phase_r == PH_PEQ) || (phase_r == PH_QVAL);

  always_comb begin
    case (frac_r)
      2'd0:    weight = 7'd100;
      2'd1:    weight = 7'd10;
      default: weight = 7'd1;
    endcase
    if (!dot_r) begin
      acc_sum = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + 15'(digit) * 15'd1000;
    end else begin
      acc_sum = 15'(acc_r) + 15'(digit) * 15'(weight);
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    len_nxt     = len_r;
    match_nxt   = match_r;
    qfound_nxt  = qfound_r;
    acc_nxt     = acc_r;
    frac_nxt    = frac_r;
    tok_nxt     = tok_r;
    started_nxt = started_r;
    neg_nxt     = neg_r;
    dot_nxt     = dot_r;
    if (step) begin
      if (is_end) begin
        phase_nxt   = PH_LEAD;
        len_nxt     = '0;
        match_nxt   = '1;
        qfound_nxt  = 1'b0;
        acc_nxt     = '0;
        frac_nxt    = '0;
        tok_nxt     = '0;
        started_nxt = 1'b0;
        neg_nxt     = 1'b0;
        dot_nxt     = 1'b0;
      end else begin
        unique case (phase_r)
          PH_LEAD:  ;
          PH_NAME:  ;
          PH_PSEP: begin
            if (!is_sep) phase_nxt = (lc == CH_LOW_Q) ? PH_PQ : PH_PSKIP;
          end
          PH_PQ: begin
            if (byte_in == CH_EQ)        phase_nxt = PH_PEQ;
            else if (byte_in == CH_SEMI) phase_nxt = PH_PSEP;
            else                         phase_nxt = PH_PSKIP;
          end
          PH_PEQ: begin
            qfound_nxt = 1'b1;
            phase_nxt  = PH_QVAL;
          end
          PH_PSKIP: begin
            if (byte_in == CH_SEMI) phase_nxt = PH_PSEP;
          end
          PH_QVAL:  ;
          PH_QDONE: ;
        endcase

        if (do_name) begin
          if (is_sep) begin
            phase_nxt = PH_PSEP;
          end else begin
            phase_nxt = PH_NAME;
            match_nxt = match_r & media_match(lc, len_r);
            if (len_r != 5'd31) len_nxt = len_r + 5'd1;
          end
        end

        if (do_value) begin
          if (is_sep || tok_r >= TOK_W'(Q_TOKEN_MAX)) begin
            phase_nxt = PH_QDONE;
          end else begin
            tok_nxt = tok_r + TOK_W'(1);
            // leading line-control chars are skipped before the number starts
            if (started_r || !(byte_in == CH_LF || byte_in == CH_CR ||
                               byte_in == CH_VT || byte_in == CH_FF)) begin
              started_nxt = 1'b1;
              if (!started_r && (byte_in == CH_PLUS || byte_in == CH_MINUS)) begin
                neg_nxt = neg_r | (byte_in == CH_MINUS);
              end else if (is_digit) begin
                if (!dot_r || frac_r != 2'd3) begin
                  acc_nxt = (acc_sum > 15'(Q_SAT)) ? Q_SAT : acc_sum[10:0];
                end
                if (dot_r && frac_r != 2'd3) frac_nxt = frac_r + 2'd1;
              end else if (byte_in == CH_DOT && !dot_r) begin
                dot_nxt = 1'b1;
              end else begin
                phase_nxt = PH_QDONE;
              end
            end
          end
        end
      end
    end
  end

  // first full-length match wins
  always_comb begin
    hit_idx = 3'(NUM_STR);
    for (int i = NUM_STR - 1; i >= 0; i--) begin
      if (match_r[i] && len_r == MEDIA_LEN[i]) hit_idx = 3'(i);
    end
  end
  assign hit = (hit_idx != 3'(NUM_STR));

  always_comb begin
    entry.done = step && is_end;
    entry.last = step && (byte_in == CH_NUL);
    entry.hit  = hit;
    case (hit_idx)
      3'd0:    entry.media = MEDIA_GEO;
      3'd1:    entry.media = MEDIA_LD;
      default: entry.media = MEDIA_JSON;
    endcase
    if (!qfound_r)   entry.q = $signed(Q_ONE);
    else if (neg_r)  entry.q = '0;
    else             entry.q = $signed((acc_r > Q_ONE) ? Q_ONE : acc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEAD;
      len_r     <= '0;
      match_r   <= '1;
      qfound_r  <= 1'b0;
      acc_r     <= '0;
      frac_r    <= '0;
      tok_r     <= '0;
      started_r <= 1'b0;
      neg_r     <= 1'b0;
      dot_r     <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      len_r     <= len_nxt;
      match_r   <= match_nxt;
      qfound_r  <= qfound_nxt;
      acc_r     <= acc_nxt;
      frac_r    <= frac_nxt;
      tok_r     <= tok_nxt;
      started_r <= started_nxt;
      neg_r     <= neg_nxt;
      dot_r     <= dot_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ahmn_select.sv
// ----------------------------------------------------------------------------
// ahmn_select
// Per-type best quality and order tracking, and the final decision.
// ----------------------------------------------------------------------------
`default_nettype none

module ahmn_select #(
  parameter int unsigned ORDER_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ahmn_pkg::ahmn_entry_t entry,
  output      ahmn_pkg::ahmn_media_t chosen
);
  import ahmn_pkg::*;

  localparam logic [ORDER_BITS-1:0] ORDER_MAX = '1;

  logic signed [10:0]    best_r   [NUM_MEDIA];
  logic signed [10:0]    best_nxt [NUM_MEDIA];
  logic [ORDER_BITS-1:0] ord_r    [NUM_MEDIA];
  logic [ORDER_BITS-1:0] ord_nxt  [NUM_MEDIA];
  logic [ORDER_BITS-1:0] cnt_r, cnt_nxt;
  logic signed [10:0]    eff      [NUM_MEDIA];
  logic signed [10:0]    bq;
  logic [ORDER_BITS-1:0] bo;

  always_comb begin
    for (int i = 0; i < NUM_MEDIA; i++) begin
      best_nxt[i] = best_r[i];
      ord_nxt[i]  = ord_r[i];
    end
    cnt_nxt = cnt_r;
    if (entry.done) begin
      if (entry.hit && entry.q > best_r[entry.media]) begin
        best_nxt[entry.media] = entry.q;
        ord_nxt[entry.media]  = cnt_r;
      end
      if (cnt_r != ORDER_MAX) cnt_nxt = cnt_r + 1'b1;
    end
  end

  // decision over the values including the closing entry
  always_comb begin
    for (int i = 0; i < NUM_MEDIA; i++) begin
      eff[i] = (best_nxt[i] == 11'sd0) ? -11'sd1 : best_nxt[i];
    end
    chosen = MEDIA_JSON;
    bq     = eff[0];
    bo     = ord_nxt[0];
    for (int i = 1; i < NUM_MEDIA; i++) begin
      if (eff[i] > bq || (eff[i] == bq && !eff[i][10] && ord_nxt[i] < bo)) begin
        chosen = ahmn_media_t'(i);
        bq     = eff[i];
        bo     = ord_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || entry.last) begin
      for (int i = 0; i < NUM_MEDIA; i++) begin
        best_r[i] <= -11'sd1;
        ord_r[i]  <= ORDER_MAX;
      end
      cnt_r <= '0;
    end else begin
      for (int i = 0; i < NUM_MEDIA; i++) begin
        best_r[i] <= best_nxt[i];
        ord_r[i]  <= ord_nxt[i];
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Header bytes stream into the media negotiator with random gaps. A local
// model of the parser predicts the chosen type for every zero byte, and the
// result side compares each returned type in order. The run covers directed
// headers, a long stall on the result side and random header traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ahmn_pkg::*;

  localparam int unsigned Q_TOKEN_MAX  = 15;
  localparam int unsigned ORDER_BITS   = 16;
  localparam int unsigned RANDOM_BYTES = 570;
  localparam int unsigned CYCLE_LIMIT  = 1500000;

  // characters with a meaning of their own in the header grammar
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  // where the parser stands inside the current entry
  typedef enum logic [2:0] {
    SCAN_LEAD, SCAN_NAME, SCAN_PSEP, SCAN_PSKIP,
    SCAN_PQ, SCAN_PEQ, SCAN_QVAL, SCAN_QDONE
  } scan_phase_t;

  logic clk;
  logic rst_n;

  ahmn_byte_if byte_ch ();
  ahmn_type_if type_ch ();

  accept_header_media_negotiator_unit #(
    .Q_TOKEN_MAX (Q_TOKEN_MAX),
    .ORDER_BITS  (ORDER_BITS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_ch),
    .out_ch (type_ch)
  );

  // fixed media strings, most specific first, as the matcher ranks them
  string media_text [5] = '{"application/geo+json", "application/ld+json",
                            "application/json", "application/*", "*/*"};

  // negotiation state of the local model
  scan_phase_t           scan_phase;
  logic [4:0]            name_len;
  logic [4:0]            name_hits;
  bit                    q_given;
  int unsigned           q_milli;
  int unsigned           q_frac_cnt;
  int unsigned           q_tok_len;
  bit                    q_started;
  bit                    q_negative;
  bit                    q_dotted;
  int                    best_q [3];
  logic [ORDER_BITS-1:0] best_order [3];
  logic [ORDER_BITS-1:0] entry_no;

  ahmn_media_t media_expected [$];   // chosen types still owed by the block
  logic [7:0]  hdr_buf [$];          // header under construction
  int unsigned failures      = 0;
  int unsigned bytes_sent    = 0;
  int unsigned cycle_count   = 0;
  int unsigned rx_hold_cycles = 0;   // one-off long stall for the result side
  bit          tx_no_gap     = 1'b0; // sender offers bytes back to back

  // --------------------------------------------------------------------------
  // local model of the negotiator
  // --------------------------------------------------------------------------
  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic bit is_sep(input logic [7:0] c);
    return c == CH_SEMI || is_blank(c);
  endfunction

  function automatic void clear_entry_state();
    scan_phase = SCAN_LEAD;
    name_len   = '0;
    name_hits  = '1;
    q_given    = 1'b0;
    q_milli    = 0;
    q_frac_cnt = 0;
    q_tok_len  = 0;
    q_started  = 1'b0;
    q_negative = 1'b0;
    q_dotted   = 1'b0;
  endfunction

  function automatic void clear_negotiation();
    clear_entry_state();
    for (int i = 0; i < 3; i++) begin
      best_q[i]     = -1;
      best_order[i] = '1;
    end
    entry_no = '0;
  endfunction

  function automatic void absorb_name_char(input logic [7:0] c);
    logic [7:0] lc;
    if (is_sep(c)) begin
      scan_phase = SCAN_PSEP;
      return;
    end
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    for (int i = 0; i < 5; i++) begin
      if (name_len >= media_text[i].len() || lc != media_text[i][name_len]) begin
        name_hits[i] = 1'b0;
      end
    end
    if (name_len < 5'd31) name_len++;
  endfunction

  // q value: optional leading line breaks, sign, digits and one dot
  function automatic void absorb_q_char(input logic [7:0] c);
    int unsigned d;
    if (is_sep(c) || q_tok_len >= Q_TOKEN_MAX) begin
      scan_phase = SCAN_QDONE;
      return;
    end
    q_tok_len++;
    if (!q_started) begin
      if (c == CH_LF || c == CH_CR || c == CH_VT || c == CH_FF) return;
      q_started = 1'b1;
      if (c == "+" || c == "-") begin
        if (c == "-") q_negative = 1'b1;
        return;
      end
    end
    if (c >= "0" && c <= "9") begin
      d = c - "0";
      if (!q_dotted) begin
        q_milli = q_milli * 10 + d * 1000;
      end else if (q_frac_cnt < 3) begin
        q_milli += d * (q_frac_cnt == 0 ? 100 : (q_frac_cnt == 1 ? 10 : 1));
        q_frac_cnt++;
      end
      if (q_milli > 1001) q_milli = 1001;
    end else if (c == "." && !q_dotted) begin
      q_dotted = 1'b1;
    end else begin
      scan_phase = SCAN_QDONE;
    end
  endfunction

  // entry closed: fold its quality into the per-type best
  function automatic void close_entry();
    int q;
    int hit;
    int kind;
    q = 1000;
    if (q_given) q = q_negative ? 0 : (q_milli > 1000 ? 1000 : int'(q_milli));
    hit = 5;
    for (int i = 0; i < 5; i++) begin
      if (hit == 5 && name_hits[i] && name_len == media_text[i].len()) hit = i;
    end
    case (hit)
      0:       kind = int'(MEDIA_GEO);
      1:       kind = int'(MEDIA_LD);
      2, 3, 4: kind = int'(MEDIA_JSON);   // wildcards count as plain json
      default: kind = -1;
    endcase
    if (kind >= 0 && q > best_q[kind]) begin
      best_q[kind]     = q;
      best_order[kind] = entry_no;
    end
    if (entry_no != '1) entry_no++;
    clear_entry_state();
  endfunction

  function automatic ahmn_media_t pick_media();
    int                    qq [3];
    int                    bq;
    logic [ORDER_BITS-1:0] bo;
    int                    best;
    for (int i = 0; i < 3; i++) qq[i] = (best_q[i] == 0) ? -1 : best_q[i];
    if (qq[0] < 0 && qq[1] < 0 && qq[2] < 0) return MEDIA_JSON;
    bq   = qq[0];
    bo   = best_order[0];
    best = 0;
    // higher quality wins, a tie goes to the earlier entry
    for (int i = 1; i < 3; i++) begin
      if (qq[i] > bq || (qq[i] == bq && qq[i] >= 0 && best_order[i] < bo)) begin
        best = i;
        bq   = qq[i];
        bo   = best_order[i];
      end
    end
    return ahmn_media_t'(best);
  endfunction

  // one accepted byte; returns 1 when the byte yields a chosen type
  function automatic bit absorb_byte(input logic [7:0] c, output ahmn_media_t pick);
    pick = MEDIA_JSON;
    if (c == CH_NUL) begin
      if (scan_phase != SCAN_LEAD) close_entry();
      pick = pick_media();
      clear_negotiation();
      return 1'b1;
    end
    if (c == CH_COMMA) begin
      close_entry();
      return 1'b0;
    end
    case (scan_phase)
      SCAN_LEAD: begin
        if (!is_blank(c)) begin
          scan_phase = SCAN_NAME;
          absorb_name_char(c);
        end
      end
      SCAN_NAME: absorb_name_char(c);
      SCAN_PSEP: begin
        if (!is_sep(c)) scan_phase = (c == "q" || c == "Q") ? SCAN_PQ : SCAN_PSKIP;
      end
      SCAN_PQ: begin
        if (c == "=") scan_phase = SCAN_PEQ;
        else scan_phase = (c == CH_SEMI) ? SCAN_PSEP : SCAN_PSKIP;
      end
      SCAN_PEQ: begin
        q_given    = 1'b1;
        scan_phase = SCAN_QVAL;
        absorb_q_char(c);
      end
      SCAN_QVAL: absorb_q_char(c);
      SCAN_PSKIP: begin
        if (c == CH_SEMI) scan_phase = SCAN_PSEP;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // header construction
  // --------------------------------------------------------------------------
  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) hdr_buf.push_back(s[i]);
  endfunction

  function automatic void add_digit();
    hdr_buf.push_back(8'("0" + $urandom_range(0, 9)));
  endfunction

  function automatic void add_blank();
    hdr_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endfunction

  // media name with letters flipped in case now and then
  function automatic void add_name(input string s);
    logic [7:0] c;
    bit         mixed;
    mixed = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mixed && (c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(0, 1)) begin
        c ^= 8'h20;
      end
      hdr_buf.push_back(c);
    end
  endfunction

  function automatic void add_q_value();
    case ($urandom_range(0, 9))
      0: add_text("0");
      1: add_text("1");
      2, 3, 4: begin
        add_text("0.");
        repeat ($urandom_range(0, 4)) add_digit();
      end
      5: begin
        add_text($urandom_range(0, 1) ? "+" : "-");
        add_digit();
        add_text(".");
        repeat ($urandom_range(0, 3)) add_digit();
      end
      6: begin
        case ($urandom_range(0, 3))
          0: hdr_buf.push_back(CH_LF);
          1: hdr_buf.push_back(CH_CR);
          2: hdr_buf.push_back(CH_VT);
          default: hdr_buf.push_back(CH_FF);
        endcase
        add_text("0.");
        repeat ($urandom_range(1, 3)) add_digit();
      end
      7: add_text("1.000");
      8: repeat ($urandom_range(1, 3)) add_digit();   // often above one, clamped
      default: begin
        case ($urandom_range(0, 5))
          0: add_text(".5");
          1: add_text("1e-3");
          2: add_text("0x1");
          3: add_text("inf");
          4: add_text("0.5.3");
          default: begin
            // token that can run longer than the parser looks at
            add_text("0.");
            repeat ($urandom_range(11, 16)) add_digit();
          end
        endcase
      end
    endcase
  endfunction

  function automatic void add_param();
    case ($urandom_range(0, 3))
      0: add_text(";");
      1: add_text(" ;");
      2: add_text("; ");
      default: add_text("\t;");
    endcase
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
        add_text($urandom_range(0, 3) == 0 ? "Q=" : "q=");
        add_q_value();
      end
      12, 13: add_text("charset=utf-8");
      14, 15: add_text("level=1");
      16: add_text("q");
      17: add_text("qx=2");
      18: add_text("q =0.5");
      default: add_text("q=");
    endcase
  endfunction

  function automatic void add_entry();
    string s;
    repeat ($urandom_range(0, 2)) add_blank();
    case ($urandom_range(0, 11))
      0, 1: add_name("application/geo+json");
      2, 3: add_name("application/ld+json");
      4, 5: add_name("application/json");
      6:    add_name("application/*");
      7:    add_name("*/*");
      8: begin
        // near miss: one character short or one too many
        s = media_text[$urandom_range(0, 4)];
        if ($urandom_range(0, 1)) add_name(s.substr(0, s.len() - 2));
        else begin
          add_name(s);
          add_text("x");
        end
      end
      9:  add_text("text/html");
      10: repeat ($urandom_range(1, 6)) hdr_buf.push_back(8'($urandom_range(1, 255)));
      default: ;   // empty entry
    endcase
    if ($urandom_range(0, 4) == 0) add_blank();
    repeat ($urandom_range(0, 2)) add_param();
  endfunction

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    ahmn_media_t pick;
    gap = tx_no_gap ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.header_byte <= b;
    // transfer happens at the first edge with ready high
    do @(posedge clk); while (!byte_ch.ready);
    if (absorb_byte(b, pick)) media_expected.push_back(pick);
    bytes_sent++;
  endtask

  // header in the buffer, then the terminator that asks for the decision
  task automatic send_buffer();
    foreach (hdr_buf[i]) send_byte(hdr_buf[i]);
    send_byte(CH_NUL);
    hdr_buf.delete();
  endtask

  task automatic send_header(input string s);
    add_text(s);
    send_buffer();
  endtask

  // sender stands back until every owed result has arrived
  task automatic settle_results(input int unsigned tail);
    byte_ch.valid <= 1'b0;
    while (media_expected.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // result side: random stalls, checks every transfer against the oldest
  // expected type
  // --------------------------------------------------------------------------
  initial begin : media_sink
    int unsigned stall;
    ahmn_media_t want;
    type_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (rx_hold_cycles != 0) begin
        stall          = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, 4);
      end
      if (stall != 0) begin
        type_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      type_ch.ready <= 1'b1;
      do @(posedge clk); while (!type_ch.valid);
      if (media_expected.size() == 0) begin
        failures++;
        $display("%0t: chosen_type expected none actual %0d", $time,
                 type_ch.chosen_type);
      end else begin
        want = media_expected.pop_front();
        if (type_ch.chosen_type !== want) begin
          failures++;
          $display("%0t: chosen_type expected %0d actual %0d", $time, want,
                   type_ch.chosen_type);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // field extremes, every media string and each parser corner
  task automatic test_plain_headers();
    string hdrs [$];
    hdrs = {
      "",
      " \t ",
      "application/json",
      "application/ld+json",
      "APPLICATION/Geo+JSON",
      "*/*",
      "application/*;q=0.8, text/html",
      "text/html, application/xml",
      "application/ld+json;q=0.5, application/geo+json;q=0.9",
      "application/geo+json, application/ld+json, application/json",
      "application/ld+json;q=0.7,application/json;q=0.7",
      "application/json;q=0, application/ld+json;q=0.000",
      ",, \t,application/geo+json;q=0.4",
      "application/ld+json ; charset=utf-8 ;level=1; q=0.3, application/json;q=0.25",
      "application/geo+json;q=,application/json;q=0.99",
      "application/ld+json;q=",
      "application/geo+json;q=\n\015\013\014+0.1239, application/json;q=0.123",
      "application/json;q=-0.5, application/ld+json;q=0.001",
      "application/ld+json;q=1e-3, application/geo+json;q=0x1, application/json;q=inf",
      "application/geo+json;q=2.5;q=0.1, application/ld+json;q=.5.3",
      "application/ld+json;q=0.00000000000009, application/json;q=0.0009",
      "application/json\200, application/ld+json\001, appl\tication/geo+json",
      "application/geo+jsonx, application/jso, */*;q=0.2, application/ld+json;q=0.1",
      "application/ld+json;qq=1;q;Q=0.6;q=0.9, application/geo+json;q=0.6",
      "application/geo+json;q=1.0009, application/json;q=+1\377"
    };
    foreach (hdrs[i]) send_header(hdrs[i]);
    settle_results(4);
  endtask

  // result side holds off while terminators pile up behind the output register
  task automatic test_result_backpressure();
    rx_hold_cycles = 80;
    tx_no_gap      = 1'b1;
    send_header("*/*");
    repeat (6) begin
      send_header("application/ld+json;q=0.5,application/geo+json");
      send_header("");
    end
    tx_no_gap = 1'b0;
    settle_results(4);
  endtask

  // mostly well-formed headers with random content, some raw noise
  task automatic test_random_headers();
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent < start + RANDOM_BYTES) begin
      tx_no_gap = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 24)) hdr_buf.push_back(8'($urandom_range(1, 255)));
      end else begin
        add_entry();
        repeat ($urandom_range(0, 3)) begin
          add_text($urandom_range(0, 1) ? "," : ", ");
          add_entry();
        end
      end
      send_buffer();
      // now and then the sender waits for the results to catch up
      if ($urandom_range(0, 15) == 0) settle_results(0);
    end
    tx_no_gap = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // clock, run control and timeout
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin : run
    rst_n               <= 1'b0;
    byte_ch.valid       <= 1'b0;
    byte_ch.header_byte <= CH_NUL;
    clear_negotiation();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_plain_headers();
    test_result_backpressure();
    test_random_headers();

    settle_results(10);
    if (failures == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ahmn_pkg.sv
rtl/ahmn_byte_if.sv
rtl/ahmn_type_if.sv
rtl/ahmn_parser.sv
rtl/ahmn_select.sv
rtl/accept_header_media_negotiator_unit.sv
tb/sv/testbench.sv
